// ----- hdl/ptld_pkg.sv -----
package ptld_pkg;

    localparam int ACC_W = 64;
    localparam int OUT_W = 63;
    localparam int MAG_W = 32;
    localparam int PC_W  = 5;
    localparam int CNT_W = 6;

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    // configuration register indexes
    localparam logic [2:0] REG_DIR_X  = 3'd0;
    localparam logic [2:0] REG_DIR_Y  = 3'd1;
    localparam logic [2:0] REG_DIR_Z  = 3'd2;
    localparam logic [2:0] REG_BASE_X = 3'd3;
    localparam logic [2:0] REG_BASE_Y = 3'd4;
    localparam logic [2:0] REG_BASE_Z = 3'd5;

    // multiplier operand A sources
    localparam logic [1:0] A_UX   = 2'd0;
    localparam logic [1:0] A_UY   = 2'd1;
    localparam logic [1:0] A_UZ   = 2'd2;
    localparam logic [1:0] A_MAGC = 2'd3;

    // multiplier operand B sources
    localparam logic [2:0] B_DX   = 3'd0;
    localparam logic [2:0] B_DY   = 3'd1;
    localparam logic [2:0] B_DZ   = 3'd2;
    localparam logic [2:0] B_MAGC = 3'd3;
    localparam logic [2:0] B_UX   = 3'd4;
    localparam logic [2:0] B_UY   = 3'd5;
    localparam logic [2:0] B_UZ   = 3'd6;

    // norm register operations
    localparam logic [1:0] N_HOLD = 2'd0;
    localparam logic [1:0] N_LOAD = 2'd1;
    localparam logic [1:0] N_ADD  = 2'd2;

    // sequencer jump kinds
    localparam logic [2:0] J_NEXT    = 3'd0;
    localparam logic [2:0] J_IN      = 3'd1;
    localparam logic [2:0] J_NOTFIN  = 3'd2;
    localparam logic [2:0] J_SKIPDIV = 3'd3;
    localparam logic [2:0] J_LOOP    = 3'd4;
    localparam logic [2:0] J_OUT     = 3'd5;
    localparam logic [2:0] J_JMP     = 3'd6;

    // jump targets
    localparam logic [PC_W-1:0] PC_IDLE = 5'd0;
    localparam logic [PC_W-1:0] PC_OUT  = 5'd18;

    typedef struct packed {
        logic            in_ld;
        logic            mul_en;
        logic [1:0]      mul_a;
        logic [2:0]      mul_b;
        logic            t_ld;
        logic            c_sub;
        logic            acc_add;
        logic [1:0]      n_op;
        logic            div_init;
        logic            div_step;
        logic            out_ld;
        logic [2:0]      jtype;
        logic [PC_W-1:0] jaddr;
    } t_ctrl;

    typedef struct packed {
        logic in_fire;
        logic final_pt;
        logic skip_div;
        logic div_last;
        logic out_fire;
    } t_stat;

    localparam t_ctrl CTRL_NOP = '{
        in_ld: 1'b0, mul_en: 1'b0, mul_a: A_UX, mul_b: B_DX, t_ld: 1'b0,
        c_sub: 1'b0, acc_add: 1'b0, n_op: N_HOLD, div_init: 1'b0,
        div_step: 1'b0, out_ld: 1'b0, jtype: J_NEXT, jaddr: PC_IDLE
    };

    // Microprogram. A product issued in one step is in the product register
    // in the next step.
    function automatic t_ctrl ucode(input logic [PC_W-1:0] pc);
        t_ctrl w;
        w = CTRL_NOP;
        unique case (pc)
            5'd0: begin
                w.in_ld = 1'b1;
                w.jtype = J_IN;
            end
            5'd1: begin
                w.mul_en = 1'b1; w.mul_a = A_UY; w.mul_b = B_DZ;
            end
            5'd2: begin
                w.mul_en = 1'b1; w.mul_a = A_UZ; w.mul_b = B_DY; w.t_ld = 1'b1;
            end
            5'd3: begin
                w.mul_en = 1'b1; w.mul_a = A_UZ; w.mul_b = B_DX; w.c_sub = 1'b1;
            end
            5'd4: begin
                w.mul_en = 1'b1; w.mul_a = A_MAGC; w.mul_b = B_MAGC; w.t_ld = 1'b1;
            end
            5'd5: begin
                w.mul_en = 1'b1; w.mul_a = A_UX; w.mul_b = B_DZ; w.acc_add = 1'b1;
            end
            5'd6: begin
                w.mul_en = 1'b1; w.mul_a = A_UX; w.mul_b = B_DY; w.c_sub = 1'b1;
            end
            5'd7: begin
                w.mul_en = 1'b1; w.mul_a = A_MAGC; w.mul_b = B_MAGC; w.t_ld = 1'b1;
            end
            5'd8: begin
                w.mul_en = 1'b1; w.mul_a = A_UY; w.mul_b = B_DX; w.acc_add = 1'b1;
            end
            5'd9: begin
                w.c_sub = 1'b1;
            end
            5'd10: begin
                w.mul_en = 1'b1; w.mul_a = A_MAGC; w.mul_b = B_MAGC;
            end
            5'd11: begin
                w.acc_add = 1'b1;
                w.jtype = J_NOTFIN; w.jaddr = PC_IDLE;
            end
            5'd12: begin
                w.mul_en = 1'b1; w.mul_a = A_UX; w.mul_b = B_UX;
            end
            5'd13: begin
                w.mul_en = 1'b1; w.mul_a = A_UY; w.mul_b = B_UY; w.n_op = N_LOAD;
            end
            5'd14: begin
                w.mul_en = 1'b1; w.mul_a = A_UZ; w.mul_b = B_UZ; w.n_op = N_ADD;
            end
            5'd15: begin
                w.n_op = N_ADD;
            end
            5'd16: begin
                w.div_init = 1'b1;
                w.jtype = J_SKIPDIV; w.jaddr = PC_OUT;
            end
            5'd17: begin
                w.div_step = 1'b1;
                w.jtype = J_LOOP;
            end
            5'd18: begin
                w.out_ld = 1'b1;
                w.jtype = J_OUT; w.jaddr = PC_IDLE;
            end
            default: begin
                w.jtype = J_JMP; w.jaddr = PC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- hdl/ptld_seq.sv -----
module ptld_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptld_pkg::t_stat   i_stat,
    output ptld_pkg::t_ctrl   o_ctrl
);

    logic [ptld_pkg::PC_W-1:0] r_pc;
    logic [ptld_pkg::PC_W-1:0] n_pc;
    logic [ptld_pkg::PC_W-1:0] pc_inc;
    ptld_pkg::t_ctrl           ctrl;

    assign ctrl   = ptld_pkg::ucode(r_pc);
    assign pc_inc = r_pc + 1'b1;
    assign o_ctrl = ctrl;

    always_comb begin
        unique case (ctrl.jtype)
            ptld_pkg::J_NEXT:    n_pc = pc_inc;
            ptld_pkg::J_IN:      n_pc = i_stat.in_fire  ? pc_inc     : r_pc;
            ptld_pkg::J_NOTFIN:  n_pc = i_stat.final_pt ? pc_inc     : ctrl.jaddr;
            ptld_pkg::J_SKIPDIV: n_pc = i_stat.skip_div ? ctrl.jaddr : pc_inc;
            ptld_pkg::J_LOOP:    n_pc = i_stat.div_last ? pc_inc     : r_pc;
            ptld_pkg::J_OUT:     n_pc = i_stat.out_fire ? ctrl.jaddr : r_pc;
            default:             n_pc = ctrl.jaddr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ptld_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ----- hdl/ptld_dp.sv -----
module ptld_dp #(
    parameter int COORD_WIDTH = 24,
    parameter int DIR_WIDTH   = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ptld_pkg::t_ctrl               i_ctrl,
    output ptld_pkg::t_stat               o_stat,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [2:0]                    i_cfg_index,
    input  logic [((COORD_WIDTH > DIR_WIDTH) ? COORD_WIDTH : DIR_WIDTH)-1:0] i_cfg_wdata,
    // point input
    input  logic                          i_in_valid,
    input  logic [COORD_WIDTH-1:0]        i_hit_x,
    input  logic [COORD_WIDTH-1:0]        i_hit_y,
    input  logic [COORD_WIDTH-1:0]        i_hit_z,
    input  logic                          i_final_hit,
    // result
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [ptld_pkg::OUT_W-1:0]    o_distance_sum,
    output logic                          o_degenerate_line,
    output logic                          o_saturated
);

    localparam int CW  = COORD_WIDTH;
    localparam int DW  = DIR_WIDTH;
    localparam int DCW = CW + 1;
    localparam int MA  = (DW > ptld_pkg::MAG_W + 1) ? DW : ptld_pkg::MAG_W + 1;
    localparam int MB  = (DCW > ptld_pkg::MAG_W + 1) ? DCW : ptld_pkg::MAG_W + 1;
    localparam int PW  = MA + MB;
    localparam int TW  = DW + DCW;
    localparam int CXW = TW + 1;
    localparam int NW  = 2 * DW;
    localparam int AW  = ptld_pkg::ACC_W;

    // configuration registers
    logic signed [DW-1:0] r_ux, r_uy, r_uz;
    logic signed [CW-1:0] r_bx, r_by, r_bz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ux <= '0; r_uy <= '0; r_uz <= '0;
            r_bx <= '0; r_by <= '0; r_bz <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                ptld_pkg::REG_DIR_X:  r_ux <= i_cfg_wdata[DW-1:0];
                ptld_pkg::REG_DIR_Y:  r_uy <= i_cfg_wdata[DW-1:0];
                ptld_pkg::REG_DIR_Z:  r_uz <= i_cfg_wdata[DW-1:0];
                ptld_pkg::REG_BASE_X: r_bx <= i_cfg_wdata[CW-1:0];
                ptld_pkg::REG_BASE_Y: r_by <= i_cfg_wdata[CW-1:0];
                ptld_pkg::REG_BASE_Z: r_bz <= i_cfg_wdata[CW-1:0];
                default: ;
            endcase
        end
    end

    // point offsets from the base point
    logic signed [DCW-1:0] r_dx, r_dy, r_dz;
    logic                  r_final;
    logic                  in_fire;

    assign in_fire = i_ctrl.in_ld && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_dx    <= {r_bx[CW-1], r_bx} - {i_hit_x[CW-1], i_hit_x};
            r_dy    <= {r_by[CW-1], r_by} - {i_hit_y[CW-1], i_hit_y};
            r_dz    <= {r_bz[CW-1], r_bz} - {i_hit_z[CW-1], i_hit_z};
            r_final <= i_final_hit;
        end
    end

    // shared multiplier and cross-product registers
    logic signed [MA-1:0]  op_a;
    logic signed [MB-1:0]  op_b;
    logic signed [PW-1:0]  r_p;
    logic signed [TW-1:0]  r_t;
    logic signed [TW-1:0]  p_tw;
    logic signed [CXW-1:0] r_c;
    logic [CXW-1:0]        mag_c;
    logic signed [ptld_pkg::MAG_W:0] magc_op;
    logic                  c_big;
    logic                  r_big;

    assign p_tw    = r_p[TW-1:0];
    assign mag_c   = r_c[CXW-1] ? CXW'(-r_c) : CXW'(r_c);
    assign c_big   = |mag_c[CXW-1:ptld_pkg::MAG_W];
    assign magc_op = {1'b0, mag_c[ptld_pkg::MAG_W-1:0]};

    always_comb begin
        unique case (i_ctrl.mul_a)
            ptld_pkg::A_UX: op_a = MA'(r_ux);
            ptld_pkg::A_UY: op_a = MA'(r_uy);
            ptld_pkg::A_UZ: op_a = MA'(r_uz);
            default:        op_a = MA'(magc_op);
        endcase
        unique case (i_ctrl.mul_b)
            ptld_pkg::B_DX:   op_b = MB'(r_dx);
            ptld_pkg::B_DY:   op_b = MB'(r_dy);
            ptld_pkg::B_DZ:   op_b = MB'(r_dz);
            ptld_pkg::B_MAGC: op_b = MB'(magc_op);
            ptld_pkg::B_UX:   op_b = MB'(r_ux);
            ptld_pkg::B_UY:   op_b = MB'(r_uy);
            default:          op_b = MB'(r_uz);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_p <= op_a * op_b;
        end
        // a component too large to square saturates the sum in the next add
        if (i_ctrl.mul_en && i_ctrl.mul_a == ptld_pkg::A_MAGC) begin
            r_big <= c_big;
        end
        if (i_ctrl.t_ld) begin
            r_t <= p_tw;
        end
        if (i_ctrl.c_sub) begin
            r_c <= CXW'(r_t) - CXW'(p_tw);
        end
    end

    // accumulator
    logic [AW-1:0] r_acc;
    logic          r_ovf;
    logic [AW:0]   acc_sum;
    logic          out_fire;

    assign acc_sum = {1'b0, r_acc} + {1'b0, r_p[AW-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_ovf <= 1'b0;
        end else if (out_fire) begin
            r_acc <= '0;
            r_ovf <= 1'b0;
        end else if (i_ctrl.acc_add) begin
            if (r_big || acc_sum[AW]) begin
                r_acc <= '1;
                r_ovf <= 1'b1;
            end else begin
                r_acc <= acc_sum[AW-1:0];
            end
        end
    end

    // squared direction length
    logic [NW-1:0] r_n;

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.n_op)
            ptld_pkg::N_LOAD: r_n <= r_p[NW-1:0];
            ptld_pkg::N_ADD:  r_n <= r_n + r_p[NW-1:0];
            default:          r_n <= r_n;
        endcase
    end

    // restoring divider, one quotient bit per step
    logic [AW-1:0]              r_quo;
    logic [NW-1:0]              r_rem;
    logic [ptld_pkg::CNT_W-1:0] r_cnt;
    logic [NW:0]                trial;
    logic [NW:0]                diff;
    logic                       fits;

    assign trial = {r_rem, r_quo[AW-1]};
    assign diff  = trial - {1'b0, r_n};
    assign fits  = trial >= {1'b0, r_n};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.div_init) begin
            r_quo <= r_acc;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_ctrl.div_step) begin
            r_quo <= {r_quo[AW-2:0], fits};
            r_rem <= fits ? diff[NW-1:0] : trial[NW-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // result register
    logic                       r_out_valid;
    logic [ptld_pkg::OUT_W-1:0] r_out_sum;
    logic                       r_out_deg;
    logic                       r_out_sat;
    logic                       degenerate;

    assign degenerate = (r_n == '0);
    assign out_fire   = i_ctrl.out_ld && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire) begin
            r_out_deg <= degenerate;
            priority if (degenerate) begin
                r_out_sum <= '0;
                r_out_sat <= r_ovf;
            end else if (r_ovf || r_quo[AW-1]) begin
                r_out_sum <= ptld_pkg::OUT_MAX;
                r_out_sat <= 1'b1;
            end else begin
                r_out_sum <= r_quo[ptld_pkg::OUT_W-1:0];
                r_out_sat <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_distance_sum    = r_out_sum;
    assign o_degenerate_line = r_out_deg;
    assign o_saturated       = r_out_sat;

    assign o_stat.in_fire  = in_fire;
    assign o_stat.final_pt = r_final;
    assign o_stat.skip_div = degenerate || r_ovf;
    assign o_stat.div_last = (r_cnt == ptld_pkg::CNT_W'(AW - 1));
    assign o_stat.out_fire = out_fire;

endmodule

// ----- hdl/point_line_distance_sum_top.sv -----
// Channel  | Dir | tdata (low bit up)                     | tuser / tlast
// ---------+-----+----------------------------------------+-------------------------------
// s_axis   | in  | hit_x, hit_y, hit_z, zero pad          | tlast = final_hit
// m_axis   | out | distance_sum, zero pad                 | tuser = degenerate_line, saturated
// cfg      | in  | wr_en, index 0..5, wdata               | dir_x/y/z, base_x/y/z
//
// A point runs 12 steps: the single shared multiplier issues the nine products
// (six cross terms, three squares). A final point adds the squared length,
// 64 one-bit divider steps and the result load; the division is skipped
// for a zero direction or overflow.
// Reset (synchronous, active low) clears the configuration registers, the sum and the step counter.
// The result register holds one result; the program stalls at its output step only
// while an earlier result is still untaken.
module point_line_distance_sum_top #(
    parameter int COORD_WIDTH = 24,
    parameter int DIR_WIDTH   = 20
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_wr_en,
    input  logic [2:0] i_cfg_index,
    input  logic [((COORD_WIDTH > DIR_WIDTH) ? COORD_WIDTH : DIR_WIDTH)-1:0] i_cfg_wdata,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // hit_x, hit_y, hit_z, zero pad
    input  logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    input  logic i_s_axis_tlast,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // distance_sum, zero pad
    output logic [((ptld_pkg::OUT_W + 7) / 8) * 8 - 1:0] o_m_axis_tdata,
    // degenerate_line, saturated
    output logic [1:0] o_m_axis_tuser
);

    localparam int CW     = COORD_WIDTH;
    localparam int OUT_TW = ((ptld_pkg::OUT_W + 7) / 8) * 8;

    ptld_pkg::t_ctrl            ctrl;
    ptld_pkg::t_stat            stat;
    logic [ptld_pkg::OUT_W-1:0] distance_sum;
    logic                       degenerate_line;
    logic                       saturated;

    ptld_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    ptld_dp #(
        .COORD_WIDTH (COORD_WIDTH),
        .DIR_WIDTH   (DIR_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctrl            (ctrl),
        .o_stat            (stat),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_s_axis_tvalid),
        .i_hit_x           (i_s_axis_tdata[CW-1:0]),
        .i_hit_y           (i_s_axis_tdata[2*CW-1:CW]),
        .i_hit_z           (i_s_axis_tdata[3*CW-1:2*CW]),
        .i_final_hit       (i_s_axis_tlast),
        .i_out_ready       (i_m_axis_tready),
        .o_out_valid       (o_m_axis_tvalid),
        .o_distance_sum    (distance_sum),
        .o_degenerate_line (degenerate_line),
        .o_saturated       (saturated)
    );

    assign o_s_axis_tready = ctrl.in_ld;
    assign o_m_axis_tdata  = OUT_TW'(distance_sum);
    assign o_m_axis_tuser  = {saturated, degenerate_line};

endmodule

// ----- hdl/ptld_checker.sv -----
module ptld_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_s_axis_tvalid,
    input logic o_s_axis_tready,
    input logic o_m_axis_tvalid,
    input logic i_m_axis_tready,
    input logic [((ptld_pkg::OUT_W + 7) / 8) * 8 - 1:0] o_m_axis_tdata,
    input logic [1:0] o_m_axis_tuser
);

    // result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result dropped before transfer");

    // a point transfer starts a multi-cycle program, so ready drops next cycle
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("point accepted while previous point in progress");

    // a zero direction always reports a zero sum
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |->
            (o_m_axis_tdata[ptld_pkg::OUT_W-1:0] == '0))
        else $error("degenerate line with nonzero sum");

    // saturation on a non-degenerate line clamps the sum to full scale
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1] && !o_m_axis_tuser[0]) |->
            (o_m_axis_tdata[ptld_pkg::OUT_W-1:0] == ptld_pkg::OUT_MAX))
        else $error("saturated result not clamped");

    // the pad bit above the sum stays zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[ptld_pkg::OUT_W] == 1'b0))
        else $error("pad bit set in result");

endmodule

bind point_line_distance_sum_top ptld_checker u_ptld_checker (.*);
